FILE: hdl/frsc_pkg.sv
// Shared types and codes for the frame region shift-copy block.
`default_nettype none

package frsc_pkg;

    // Parameter defaults
    localparam int DEF_MAX_WIDTH    = 128;
    localparam int DEF_MAX_HEIGHT   = 128;
    localparam int DEF_MAX_CHANNELS = 4;
    localparam int DEF_SAMPLE_BITS  = 8;

    // Item kinds
    localparam logic [1:0] KIND_WRITE = 2'd0;
    localparam logic [1:0] KIND_READ  = 2'd1;
    localparam logic [1:0] KIND_MOVE  = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] CFG_IMAGE_WIDTH   = 2'd0;
    localparam logic [1:0] CFG_IMAGE_HEIGHT  = 2'd1;
    localparam logic [1:0] CFG_CHANNEL_COUNT = 2'd2;

    // Move command as held for the scan unit, with the image geometry in use
    typedef struct packed {
        logic [7:0]        sel_left;
        logic [7:0]        sel_right;
        logic [7:0]        sel_top;
        logic [7:0]        sel_bottom;
        logic signed [7:0] shift_x;
        logic signed [7:0] shift_y;
        logic [7:0]        img_w;
        logic [7:0]        img_h;
        logic [2:0]        chans;
    } move_cmd_t;

    // Scan unit memory strobes and completion
    typedef struct packed {
        logic rd_en;
        logic wr_en;
        logic done;
    } scan_ctl_t;

endpackage

`default_nettype wire

FILE: hdl/frsc_ram.sv
// Generic simple dual-port RAM, one write port, one registered read port.
`default_nettype none

module frsc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             aclk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // read-first on a same-address collision; rdata holds while re is low
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

FILE: hdl/frsc_walk.sv
// Move scan unit: clips the destination and walks it, one read and one write per sample.
`default_nettype none

module frsc_walk #(
    parameter int MAX_WIDTH    = frsc_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT   = frsc_pkg::DEF_MAX_HEIGHT,
    parameter int MAX_CHANNELS = frsc_pkg::DEF_MAX_CHANNELS,
    localparam int XW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1,
    localparam int YW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1,
    localparam int CW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1,
    localparam int AW = XW + YW + CW
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                start,
    input  wire frsc_pkg::move_cmd_t cmd,
    output frsc_pkg::scan_ctl_t      ctl,
    output logic [AW-1:0]            rd_addr,
    output logic [AW-1:0]            wr_addr
);

    import frsc_pkg::*;

    typedef enum logic [3:0] {
        W_IDLE  = 4'b0001,
        W_SETUP = 4'b0010,
        W_RUN   = 4'b0100,
        W_DRAIN = 4'b1000
    } walk_state_t;

    walk_state_t state_reg, state_next;

    logic [7:0] x_reg, x_next, y_reg, y_next;
    logic [7:0] x_lim_reg, x_lim_next, y_lim_reg, y_lim_next;
    logic [7:0] y_start_reg, y_start_next;
    logic       x_dec_reg, x_dec_next, y_dec_reg, y_dec_next;
    logic [1:0] s_reg, s_next;
    logic       wr_en_reg;
    logic [AW-1:0] wr_addr_reg;

    logic              rd_en, done;
    logic signed [9:0] sx, sy, w10, h10;
    logic signed [9:0] dl, dr, dt, db;
    logic              empty;
    logic [7:0]        x_src, y_src;
    logic [AW-1:0]     dst_addr;

    // destination window: shifted selection, clipped to the image and to
    // positions whose source is inside the image
    always_comb begin
        sx  = $signed({{2{cmd.shift_x[7]}}, cmd.shift_x});
        sy  = $signed({{2{cmd.shift_y[7]}}, cmd.shift_y});
        w10 = $signed({2'b00, cmd.img_w});
        h10 = $signed({2'b00, cmd.img_h});

        dl = $signed({2'b00, cmd.sel_left}) + sx;
        if (dl < 10'sd0) dl = 10'sd0;
        if (dl < sx)     dl = sx;
        dr = $signed({2'b00, cmd.sel_right}) + sx;
        if (dr > w10)      dr = w10;
        if (dr > w10 + sx) dr = w10 + sx;

        dt = $signed({2'b00, cmd.sel_top}) + sy;
        if (dt < 10'sd0) dt = 10'sd0;
        if (dt < sy)     dt = sy;
        db = $signed({2'b00, cmd.sel_bottom}) + sy;
        if (db > h10)      db = h10;
        if (db > h10 + sy) db = h10 + sy;

        empty = (dl >= dr) || (dt >= db) || ((sx == 10'sd0) && (sy == 10'sd0));
    end

    // source sits at destination minus shift; in range by the clipping above
    assign x_src    = x_reg - $unsigned(cmd.shift_x);
    assign y_src    = y_reg - $unsigned(cmd.shift_y);
    assign dst_addr = {CW'(s_reg), YW'(y_reg), XW'(x_reg)};
    assign rd_addr  = {CW'(s_reg), YW'(y_src), XW'(x_src)};
    assign wr_addr  = wr_addr_reg;

    assign ctl.rd_en = rd_en;
    assign ctl.wr_en = wr_en_reg;
    assign ctl.done  = done;

    always_comb begin
        state_next   = state_reg;
        x_next       = x_reg;
        y_next       = y_reg;
        s_next       = s_reg;
        x_lim_next   = x_lim_reg;
        y_lim_next   = y_lim_reg;
        y_start_next = y_start_reg;
        x_dec_next   = x_dec_reg;
        y_dec_next   = y_dec_reg;
        rd_en        = 1'b0;
        done         = 1'b0;

        unique case (state_reg)
            W_IDLE: begin
                if (start) begin
                    state_next = W_SETUP;
                end
            end
            W_SETUP: begin
                if (empty) begin
                    done       = 1'b1;
                    state_next = W_IDLE;
                end else begin
                    // scan each axis against its shift
                    x_dec_next   = (sx > 10'sd0);
                    y_dec_next   = (sy > 10'sd0);
                    x_next       = (sx > 10'sd0) ? 8'(dr - 10'sd1) : 8'(dl);
                    x_lim_next   = (sx > 10'sd0) ? 8'(dl) : 8'(dr - 10'sd1);
                    y_start_next = (sy > 10'sd0) ? 8'(db - 10'sd1) : 8'(dt);
                    y_next       = (sy > 10'sd0) ? 8'(db - 10'sd1) : 8'(dt);
                    y_lim_next   = (sy > 10'sd0) ? 8'(dt) : 8'(db - 10'sd1);
                    s_next       = 2'd0;
                    state_next   = W_RUN;
                end
            end
            W_RUN: begin
                rd_en = 1'b1;
                if ({1'b0, s_reg} == cmd.chans - 3'd1) begin
                    s_next = 2'd0;
                    if (y_reg == y_lim_reg) begin
                        y_next = y_start_reg;
                        if (x_reg == x_lim_reg) begin
                            state_next = W_DRAIN;
                        end else begin
                            x_next = x_dec_reg ? x_reg - 8'd1 : x_reg + 8'd1;
                        end
                    end else begin
                        y_next = y_dec_reg ? y_reg - 8'd1 : y_reg + 8'd1;
                    end
                end else begin
                    s_next = s_reg + 2'd1;
                end
            end
            W_DRAIN: begin
                // last write goes out this cycle
                done       = 1'b1;
                state_next = W_IDLE;
            end
            default: begin
                state_next = W_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= W_IDLE;
            wr_en_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            wr_en_reg <= rd_en;
        end
    end

    always_ff @(posedge aclk) begin
        x_reg       <= x_next;
        y_reg       <= y_next;
        s_reg       <= s_next;
        x_lim_reg   <= x_lim_next;
        y_lim_reg   <= y_lim_next;
        y_start_reg <= y_start_next;
        x_dec_reg   <= x_dec_next;
        y_dec_reg   <= y_dec_next;
        wr_addr_reg <= dst_addr;
    end

`ifndef NO_ASSERTIONS
    // the scan order never reads the entry being written in the same cycle
    a_no_rw_collision: assert property (@(posedge aclk) disable iff (!aresetn)
        (rd_en && wr_en_reg) |-> (rd_addr != wr_addr_reg))
        else $error("move read collides with pending write");

    // every read is followed by its write-back
    a_read_then_write: assert property (@(posedge aclk) disable iff (!aresetn)
        rd_en |=> wr_en_reg)
        else $error("move read without write-back");

    // completion is a single-cycle pulse
    a_done_pulse: assert property (@(posedge aclk) disable iff (!aresetn)
        done |=> !done)
        else $error("move done held for more than one cycle");
`endif

endmodule

`default_nettype wire

FILE: hdl/frame_region_shift_copy.sv
// Top level of the frame region shift-copy block: handshakes, configuration and frame store.
`default_nettype none

// Frame store of samples addressed by column, row and channel, taking three
// kinds of beat: write one sample, read one sample, or move a rectangular
// selection by a signed shift. Every input beat gives exactly one result beat
// (read_sample, zero unless a read inside the image; done_kind echoes kind).
// A move copies every channel in use and scans each axis against its shift,
// so overlapping source and destination behave as if copied from the frame
// before the move; the destination is clipped to the image and to positions
// whose source is inside it, and a zero shift or empty window does nothing.
// A write, read or unused kind passes through the finishing state. A move
// copies N = clipped columns x rows x channel_count samples, one source read
// per cycle on the single read port of the frame RAM, the write-back on the
// write port in the next cycle. Input is taken only while the block is idle,
// but a finished result may wait in the output register while the next beat
// is accepted. The frame store is not cleared: a sample never written reads
// undefined. Configuration (width, height, channel count, saturated to 1..MAX)
// must be written only while idle; the block does not enforce this. The
// port has no read-back and indexes beyond channel count are ignored.

module frame_region_shift_copy #(
    parameter int MAX_WIDTH    = frsc_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT   = frsc_pkg::DEF_MAX_HEIGHT,
    parameter int MAX_CHANNELS = frsc_pkg::DEF_MAX_CHANNELS,
    parameter int SAMPLE_BITS  = frsc_pkg::DEF_SAMPLE_BITS
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    // configuration
    input  wire logic              cfg_wr_en,
    input  wire logic [1:0]        cfg_index,
    input  wire logic [7:0]        cfg_data,
    // input beats
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire logic [1:0]        s_kind,
    input  wire logic [6:0]        s_col,
    input  wire logic [6:0]        s_row,
    input  wire logic [1:0]        s_channel,
    input  wire logic [7:0]        s_sample,
    input  wire logic [7:0]        s_sel_left,
    input  wire logic [7:0]        s_sel_right,
    input  wire logic [7:0]        s_sel_top,
    input  wire logic [7:0]        s_sel_bottom,
    input  wire logic signed [7:0] s_shift_x,
    input  wire logic signed [7:0] s_shift_y,
    // result beats
    output logic                   m_valid,
    input  wire logic              m_ready,
    output logic [7:0]             m_read_sample,
    output logic [1:0]             m_done_kind
);

    import frsc_pkg::*;

    localparam int XW    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int YW    = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int CW    = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int AW    = XW + YW + CW;
    localparam int DEPTH = 1 << AW;

    // reset geometry: 128 x 128, one channel, saturated to the store size
    localparam logic [7:0] WIDTH_RST  = (MAX_WIDTH < 128) ? 8'(MAX_WIDTH) : 8'd128;
    localparam logic [7:0] HEIGHT_RST = (MAX_HEIGHT < 128) ? 8'(MAX_HEIGHT) : 8'd128;

    typedef enum logic [2:0] {
        T_IDLE = 3'b001,
        T_MOVE = 3'b010,
        T_FIN  = 3'b100
    } top_state_t;

    top_state_t state_reg, state_next;

    logic [7:0] img_w_reg, img_h_reg;
    logic [2:0] chans_reg;

    // held beat
    logic [1:0]        kind_reg;
    logic              rd_hit_reg;
    logic [7:0]        sel_left_reg, sel_right_reg, sel_top_reg, sel_bottom_reg;
    logic signed [7:0] shift_x_reg, shift_y_reg;

    // output register
    logic       m_valid_reg, m_valid_next;
    logic [7:0] m_sample_reg;
    logic [1:0] m_kind_reg;

    logic        accept, in_frame, out_free, load_out;
    logic        port_we, port_re;
    logic [AW-1:0] port_addr;
    move_cmd_t   cmd;
    scan_ctl_t   walk_ctl;
    logic [AW-1:0] walk_raddr, walk_waddr;

    logic                   ram_we, ram_re;
    logic [AW-1:0]          ram_waddr, ram_raddr;
    logic [SAMPLE_BITS-1:0] ram_wdata, ram_rdata;

    assign s_ready  = (state_reg == T_IDLE);
    assign accept   = s_valid && s_ready;
    assign in_frame = ({1'b0, s_col} < img_w_reg) && ({1'b0, s_row} < img_h_reg) &&
                      ({1'b0, s_channel} < chans_reg);
    assign out_free = !m_valid_reg || m_ready;

    // single-sample accesses go straight to the RAM on the accepting edge
    assign port_we   = accept && (s_kind == KIND_WRITE) && in_frame;
    assign port_re   = accept && (s_kind == KIND_READ) && in_frame;
    assign port_addr = {CW'(s_channel), YW'(s_row), XW'(s_col)};

    assign cmd.sel_left   = sel_left_reg;
    assign cmd.sel_right  = sel_right_reg;
    assign cmd.sel_top    = sel_top_reg;
    assign cmd.sel_bottom = sel_bottom_reg;
    assign cmd.shift_x    = shift_x_reg;
    assign cmd.shift_y    = shift_y_reg;
    assign cmd.img_w      = img_w_reg;
    assign cmd.img_h      = img_h_reg;
    assign cmd.chans      = chans_reg;

    frsc_walk #(
        .MAX_WIDTH    (MAX_WIDTH),
        .MAX_HEIGHT   (MAX_HEIGHT),
        .MAX_CHANNELS (MAX_CHANNELS)
    ) u_walk (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (accept && (s_kind == KIND_MOVE)),
        .cmd     (cmd),
        .ctl     (walk_ctl),
        .rd_addr (walk_raddr),
        .wr_addr (walk_waddr)
    );

    // move traffic and single-sample traffic never overlap in time
    assign ram_we    = port_we || walk_ctl.wr_en;
    assign ram_waddr = walk_ctl.wr_en ? walk_waddr : port_addr;
    assign ram_wdata = walk_ctl.wr_en ? ram_rdata : SAMPLE_BITS'(s_sample);
    assign ram_re    = port_re || walk_ctl.rd_en;
    assign ram_raddr = walk_ctl.rd_en ? walk_raddr : port_addr;

    frsc_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (DEPTH)
    ) u_frame (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_comb begin
        state_next = state_reg;
        load_out   = 1'b0;
        unique case (state_reg)
            T_IDLE: begin
                if (accept) begin
                    state_next = (s_kind == KIND_MOVE) ? T_MOVE : T_FIN;
                end
            end
            T_MOVE: begin
                if (walk_ctl.done) begin
                    state_next = T_FIN;
                end
            end
            T_FIN: begin
                // read data stays in the RAM output register while stalled
                if (out_free) begin
                    load_out   = 1'b1;
                    state_next = T_IDLE;
                end
            end
            default: begin
                state_next = T_IDLE;
            end
        endcase
    end

    assign m_valid_next = load_out ? 1'b1 : (m_ready ? 1'b0 : m_valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= T_IDLE;
            m_valid_reg <= 1'b0;
            img_w_reg   <= WIDTH_RST;
            img_h_reg   <= HEIGHT_RST;
            chans_reg   <= 3'd1;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            if (cfg_wr_en) begin
                unique case (cfg_index)
                    CFG_IMAGE_WIDTH: begin
                        img_w_reg <= (cfg_data == 8'd0) ? 8'd1 :
                                     (32'(cfg_data) > MAX_WIDTH) ? 8'(MAX_WIDTH) : cfg_data;
                    end
                    CFG_IMAGE_HEIGHT: begin
                        img_h_reg <= (cfg_data == 8'd0) ? 8'd1 :
                                     (32'(cfg_data) > MAX_HEIGHT) ? 8'(MAX_HEIGHT) : cfg_data;
                    end
                    CFG_CHANNEL_COUNT: begin
                        chans_reg <= (cfg_data[2:0] == 3'd0) ? 3'd1 :
                                     (32'(cfg_data[2:0]) > MAX_CHANNELS) ?
                                     3'(MAX_CHANNELS) : cfg_data[2:0];
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            kind_reg       <= s_kind;
            rd_hit_reg     <= (s_kind == KIND_READ) && in_frame;
            sel_left_reg   <= s_sel_left;
            sel_right_reg  <= s_sel_right;
            sel_top_reg    <= s_sel_top;
            sel_bottom_reg <= s_sel_bottom;
            shift_x_reg    <= s_shift_x;
            shift_y_reg    <= s_shift_y;
        end
        if (load_out) begin
            m_sample_reg <= rd_hit_reg ? 8'(ram_rdata) : 8'd0;
            m_kind_reg   <= kind_reg;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_read_sample = m_sample_reg;
    assign m_done_kind   = m_kind_reg;

`ifndef NO_ASSERTIONS
    // the scan unit only completes while a move is outstanding
    a_done_in_move: assert property (@(posedge aclk) disable iff (!aresetn)
        walk_ctl.done |-> (state_reg == T_MOVE))
        else $error("scan done outside a move");

    // single-sample writes never contend with move write-backs
    a_one_writer: assert property (@(posedge aclk) disable iff (!aresetn)
        !(port_we && walk_ctl.wr_en))
        else $error("two writers on the frame RAM");

    // a result only appears after the finishing state
    a_result_from_fin: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == T_FIN))
        else $error("result raised outside finishing state");
`endif

endmodule

`default_nettype wire
